@@ design/assoc_page_table_replacement_core_macros.svh @@
// Assertion macros used by the checker of the page table core
`ifndef ASSOC_PAGE_TABLE_REPLACEMENT_CORE_MACROS_SVH
`define ASSOC_PAGE_TABLE_REPLACEMENT_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted
`define APTR_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted
`define APTR_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/aptr_pkg.sv @@
// Types and codes of the page table replacement core
package aptr_pkg;

    localparam logic [1:0] KIND_ACCESS = 2'd0;
    localparam logic [1:0] KIND_INVAL  = 2'd1;
    localparam logic [1:0] KIND_STATS  = 2'd2;
    localparam logic [1:0] KIND_NOP    = 2'd3;

    localparam logic [1:0] POLICY_FIFO  = 2'd0;
    localparam logic [1:0] POLICY_LRU   = 2'd1;
    localparam logic [1:0] POLICY_LFU   = 2'd2;
    localparam logic [1:0] POLICY_SWEEP = 2'd3;

    localparam logic [31:0] TIME_RESET = 32'd1;

    typedef struct packed {
        logic [15:0] owner;
        logic [19:0] page;
        logic [31:0] recent;
        logic [31:0] uses;
        logic [31:0] insert;
    } slot_entry_t;

    typedef struct packed {
        logic       clear;
        logic       step;
        logic [1:0] policy;
    } scan_ctl_t;

    typedef struct packed {
        logic hit_found;
        logic free_found;
    } scan_flags_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SCAN   = 6'b000010,
        ST_DECIDE = 6'b000100,
        ST_CLOCK  = 6'b001000,
        ST_WRITE  = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

endpackage

@@ design/aptr_slot_mem.sv @@
// Slot metadata memory: one write port, one registered read port
module aptr_slot_mem #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  aptr_pkg::slot_entry_t      wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output aptr_pkg::slot_entry_t      rdata
);

    aptr_pkg::slot_entry_t mem [DEPTH];
    aptr_pkg::slot_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/aptr_scan.sv @@
// Per-slot scan: hit match, first free slot and victim candidate
module aptr_scan #(
    parameter int SLOT_W = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  aptr_pkg::scan_ctl_t    ctl,
    input  logic [SLOT_W-1:0]      idx,
    input  logic                   valid,
    input  aptr_pkg::slot_entry_t  entry,
    input  logic [15:0]            pid,
    input  logic [19:0]            page,
    output aptr_pkg::scan_flags_t  flags,
    output logic [SLOT_W-1:0]      hit_idx,
    output aptr_pkg::slot_entry_t  hit_entry,
    output logic [SLOT_W-1:0]      free_idx,
    output logic [SLOT_W-1:0]      best_idx
);

    aptr_pkg::scan_flags_t flags_reg;
    aptr_pkg::slot_entry_t hit_entry_reg;
    aptr_pkg::slot_entry_t best_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic [SLOT_W-1:0]     free_idx_reg;
    logic [SLOT_W-1:0]     best_idx_reg;
    logic                  best_vld_reg;
    logic                  match;
    logic                  better;

    assign match = valid && (entry.owner == pid) && (entry.page == page);

    always_comb
    begin
        case (ctl.policy)
            aptr_pkg::POLICY_FIFO: better = entry.insert < best_reg.insert;
            aptr_pkg::POLICY_LRU:  better = entry.recent < best_reg.recent;
            default:               better = (entry.uses < best_reg.uses) ||
                                            ((entry.uses == best_reg.uses) &&
                                             (entry.recent < best_reg.recent));
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg    <= '0;
            best_vld_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            flags_reg    <= '0;
            best_vld_reg <= 1'b0;
        end
        else if (ctl.step)
        begin
            if (match && !flags_reg.hit_found)
            begin
                flags_reg.hit_found <= 1'b1;
            end
            if (!valid && !flags_reg.free_found)
            begin
                flags_reg.free_found <= 1'b1;
            end
            best_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step)
        begin
            if (match && !flags_reg.hit_found)
            begin
                hit_idx_reg   <= idx;
                hit_entry_reg <= entry;
            end
            if (!valid && !flags_reg.free_found)
            begin
                free_idx_reg <= idx;
            end
            // keep the lowest slot among equal keys
            if (!best_vld_reg || better)
            begin
                best_idx_reg <= idx;
                best_reg     <= entry;
            end
        end
    end

    assign flags     = flags_reg;
    assign hit_idx   = hit_idx_reg;
    assign hit_entry = hit_entry_reg;
    assign free_idx  = free_idx_reg;
    assign best_idx  = best_idx_reg;

endmodule

@@ design/assoc_page_table_replacement_core.sv @@
// Top level of the fully associative page table with selectable replacement
//
// Input channel: raise start with kind, process_id, page_number and
// page_mapped; the transaction is taken at a clock edge where busy is low.
// Result channel: done pulses for one cycle with success, was_hit,
// slot_index, did_evict and the four statistics totals; the receiver
// cannot stall, so results are never held back.
// Configuration: policy_we writes policy_wdata into the replacement policy
// register (reset value LFU); write it only while busy is low.
// Sequence: a mapped access scans every slot through the single read port of
// the metadata memory, one slot per cycle, then passes the decide, write-back
// and finish states before done rises. An invalidate or a statistics reset
// skips the write-back. A CLOCK eviction adds the clock state between decide
// and write-back, passing set reference marks until it finds the victim.
// Unmapped accesses and unknown kinds go straight to finish. busy falls as
// done rises.
// Reset: all slots invalid, logical time 1, statistics off and zero; no
// memory clearing pass is needed since invalid slot contents are ignored.
module assoc_page_table_replacement_core #(
    parameter int SLOT_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [15:0] process_id,
    input  logic [19:0] page_number,
    input  logic        page_mapped,
    input  logic        policy_we,
    input  logic [1:0]  policy_wdata,
    output logic        done,
    output logic        success,
    output logic        was_hit,
    output logic [3:0]  slot_index,
    output logic        did_evict,
    output logic [31:0] access_total,
    output logic [31:0] hit_total,
    output logic [31:0] miss_total,
    output logic [31:0] evict_total
);

    localparam int SLOT_W = $clog2(SLOT_COUNT);
    localparam logic [SLOT_W:0]   SCAN_END = (SLOT_W+1)'(SLOT_COUNT);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    aptr_pkg::state_t state_reg, state_next;

    // latched transaction
    logic [1:0]  kind_reg;
    logic [15:0] pid_reg;
    logic [19:0] page_reg;
    logic        mapped_reg;

    logic [1:0]            policy_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] ref_reg;
    logic [SLOT_W-1:0]     sweep_reg;
    logic [31:0]           time_reg;
    logic [15:0]           tracked_reg;
    logic                  tracking_reg;
    logic [31:0]           access_cnt_reg;
    logic [31:0]           hit_cnt_reg;
    logic [31:0]           miss_cnt_reg;
    logic [31:0]           evict_cnt_reg;

    logic [SLOT_W:0]   cnt_reg;
    logic [SLOT_W-1:0] target_reg;
    logic              hit_reg;
    logic              evict_reg;

    logic        done_reg;
    logic        success_reg;
    logic        was_hit_reg;
    logic [3:0]  slot_reg;
    logic        did_evict_reg;

    logic                  accept;
    logic                  is_access;
    logic                  counted;
    logic [SLOT_W-1:0]     scan_idx;
    logic [SLOT_W-1:0]     sweep_inc;
    logic [SLOT_W+3:0]     slot_wide;
    aptr_pkg::scan_ctl_t   scan_ctl;
    aptr_pkg::scan_flags_t scan_flags;
    aptr_pkg::slot_entry_t rd_entry;
    aptr_pkg::slot_entry_t wr_entry;
    aptr_pkg::slot_entry_t hit_entry;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     best_idx;
    logic                  wr_en;

    assign accept    = start && (state_reg == aptr_pkg::ST_IDLE);
    assign busy      = (state_reg != aptr_pkg::ST_IDLE);
    assign is_access = (kind_reg == aptr_pkg::KIND_ACCESS);
    assign counted   = tracking_reg && (pid_reg == tracked_reg);
    assign scan_idx  = SLOT_W'(cnt_reg - 1'b1);
    assign sweep_inc = (sweep_reg == SLOT_LAST) ? '0 : sweep_reg + 1'b1;
    assign slot_wide = {4'b0, target_reg};

    // scan the slot that the registered memory read presents in the cycle after its address
    assign scan_ctl.clear  = accept;
    assign scan_ctl.step   = (state_reg == aptr_pkg::ST_SCAN) && (cnt_reg != '0);
    assign scan_ctl.policy = policy_reg;

    aptr_slot_mem #(
        .DEPTH (SLOT_COUNT)
    ) u_mem (
        .clk   (clk),
        .we    (wr_en),
        .waddr (target_reg),
        .wdata (wr_entry),
        .raddr (cnt_reg[SLOT_W-1:0]),
        .rdata (rd_entry)
    );

    aptr_scan #(
        .SLOT_W (SLOT_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (scan_ctl),
        .idx       (scan_idx),
        .valid     (valid_reg[scan_idx]),
        .entry     (rd_entry),
        .pid       (pid_reg),
        .page      (page_reg),
        .flags     (scan_flags),
        .hit_idx   (hit_idx),
        .hit_entry (hit_entry),
        .free_idx  (free_idx),
        .best_idx  (best_idx)
    );

    // write back: refresh a hit, or fill a new mapping
    assign wr_en = (state_reg == aptr_pkg::ST_WRITE);
    always_comb
    begin
        if (hit_reg)
        begin
            wr_entry        = hit_entry;
            wr_entry.recent = time_reg;
            wr_entry.uses   = hit_entry.uses + 32'd1;
        end
        else
        begin
            wr_entry.owner  = pid_reg;
            wr_entry.page   = page_reg;
            wr_entry.insert = time_reg;
            wr_entry.recent = time_reg + 32'd1;
            wr_entry.uses   = 32'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            aptr_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (((kind == aptr_pkg::KIND_ACCESS) && page_mapped) ||
                        (kind == aptr_pkg::KIND_INVAL) || (kind == aptr_pkg::KIND_STATS))
                    begin
                        state_next = aptr_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = aptr_pkg::ST_FINISH;
                    end
                end
            end
            aptr_pkg::ST_SCAN:
            begin
                if (cnt_reg == SCAN_END)
                begin
                    state_next = aptr_pkg::ST_DECIDE;
                end
            end
            aptr_pkg::ST_DECIDE:
            begin
                if (!is_access)
                begin
                    state_next = aptr_pkg::ST_FINISH;
                end
                else if (!scan_flags.hit_found && !scan_flags.free_found &&
                         (policy_reg == aptr_pkg::POLICY_SWEEP))
                begin
                    state_next = aptr_pkg::ST_CLOCK;
                end
                else
                begin
                    state_next = aptr_pkg::ST_WRITE;
                end
            end
            aptr_pkg::ST_CLOCK:
            begin
                if (!ref_reg[sweep_reg])
                begin
                    state_next = aptr_pkg::ST_WRITE;
                end
            end
            aptr_pkg::ST_WRITE:  state_next = aptr_pkg::ST_FINISH;
            aptr_pkg::ST_FINISH: state_next = aptr_pkg::ST_IDLE;
            default:             state_next = aptr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= aptr_pkg::ST_IDLE;
            policy_reg     <= aptr_pkg::POLICY_LFU;
            valid_reg      <= '0;
            ref_reg        <= '0;
            sweep_reg      <= '0;
            time_reg       <= aptr_pkg::TIME_RESET;
            tracked_reg    <= '0;
            tracking_reg   <= 1'b0;
            access_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            evict_cnt_reg  <= '0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            evict_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == aptr_pkg::ST_FINISH);
            if (policy_we)
            begin
                policy_reg <= policy_wdata;
            end
            unique case (state_reg)
                aptr_pkg::ST_IDLE:
                begin
                    cnt_reg   <= '0;
                    hit_reg   <= 1'b0;
                    evict_reg <= 1'b0;
                end
                aptr_pkg::ST_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    // drop every valid slot owned by the process
                    if (scan_ctl.step && !is_access && valid_reg[scan_idx] &&
                        (rd_entry.owner == pid_reg))
                    begin
                        valid_reg[scan_idx] <= 1'b0;
                        ref_reg[scan_idx]   <= 1'b0;
                    end
                end
                aptr_pkg::ST_DECIDE:
                begin
                    if (kind_reg == aptr_pkg::KIND_STATS)
                    begin
                        sweep_reg      <= '0;
                        time_reg       <= aptr_pkg::TIME_RESET;
                        tracked_reg    <= pid_reg;
                        tracking_reg   <= 1'b1;
                        access_cnt_reg <= '0;
                        hit_cnt_reg    <= '0;
                        miss_cnt_reg   <= '0;
                        evict_cnt_reg  <= '0;
                    end
                    hit_reg   <= scan_flags.hit_found;
                    evict_reg <= !scan_flags.hit_found && !scan_flags.free_found;
                end
                aptr_pkg::ST_CLOCK:
                begin
                    // pass marked slots, clearing their marks
                    ref_reg[sweep_reg] <= 1'b0;
                    sweep_reg          <= sweep_inc;
                end
                aptr_pkg::ST_WRITE:
                begin
                    valid_reg[target_reg] <= 1'b1;
                    ref_reg[target_reg]   <= 1'b1;
                    time_reg <= hit_reg ? time_reg + 32'd1 : time_reg + 32'd2;
                    if (counted)
                    begin
                        access_cnt_reg <= access_cnt_reg + 32'd1;
                        if (hit_reg)
                        begin
                            hit_cnt_reg <= hit_cnt_reg + 32'd1;
                        end
                        else
                        begin
                            miss_cnt_reg <= miss_cnt_reg + 32'd1;
                        end
                        if (evict_reg)
                        begin
                            evict_cnt_reg <= evict_cnt_reg + 32'd1;
                        end
                    end
                end
                aptr_pkg::ST_FINISH:
                begin
                    cnt_reg <= '0;
                end
                default:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    // transaction payload and result fields
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= kind;
            pid_reg    <= process_id;
            page_reg   <= page_number;
            mapped_reg <= page_mapped;
        end
        if (state_reg == aptr_pkg::ST_DECIDE)
        begin
            if (scan_flags.hit_found)
            begin
                target_reg <= hit_idx;
            end
            else if (scan_flags.free_found)
            begin
                target_reg <= free_idx;
            end
            else
            begin
                target_reg <= best_idx;
            end
        end
        if ((state_reg == aptr_pkg::ST_CLOCK) && !ref_reg[sweep_reg])
        begin
            target_reg <= sweep_reg;
        end
        if (state_reg == aptr_pkg::ST_FINISH)
        begin
            success_reg   <= !(is_access && !mapped_reg);
            was_hit_reg   <= is_access && mapped_reg && hit_reg;
            did_evict_reg <= is_access && mapped_reg && evict_reg;
            slot_reg      <= (is_access && mapped_reg) ? slot_wide[3:0] : 4'd0;
        end
    end

    assign done         = done_reg;
    assign success      = success_reg;
    assign was_hit      = was_hit_reg;
    assign slot_index   = slot_reg;
    assign did_evict    = did_evict_reg;
    assign access_total = access_cnt_reg;
    assign hit_total    = hit_cnt_reg;
    assign miss_total   = miss_cnt_reg;
    assign evict_total  = evict_cnt_reg;

endmodule

@@ design/aptr_checker.sv @@
// Port-level checker for the page table core, bound to the top level
`include "assoc_page_table_replacement_core_macros.svh"

module aptr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       success,
    input logic       was_hit,
    input logic       did_evict,
    input logic [3:0] slot_index
);

    `APTR_CHK_NXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")
    `APTR_CHK_NXT(a_done_pulse, done, !done, "result strobe longer than one cycle")
    `APTR_CHK_NOW(a_done_idle, done, !busy, "result strobe while still busy")
    `APTR_CHK_NOW(a_hit_clean, done && was_hit, success && !did_evict, "hit with eviction or failure")
    `APTR_CHK_NOW(a_fail_zero, done && !success, !was_hit && !did_evict && (slot_index == 4'd0),
                  "failed access reported a slot")

endmodule

bind assoc_page_table_replacement_core aptr_checker u_aptr_checker (.*);

@@ sim/testbench.sv @@
// Self-checking testbench of the page table replacement core
`timescale 1ns / 1ps

module testbench;

    localparam int NSLOT = 16;
    localparam int WATCH_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pid;
        logic [19:0] page;
        logic        mapped;
        logic        wr_pol;   // policy write marker, not a transaction
        logic [1:0]  pol;
    } req_t;

    typedef struct packed {
        logic        success;
        logic        hit;
        logic [3:0]  slot;
        logic        evict;
        logic [31:0] acc;
        logic [31:0] hits;
        logic [31:0] miss;
        logic [31:0] evs;
    } resp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] kind = aptr_pkg::KIND_ACCESS;
    logic [15:0] process_id = '0;
    logic [19:0] page_number = '0;
    logic page_mapped = 1'b0;
    logic policy_we = 1'b0;
    logic [1:0] policy_wdata = aptr_pkg::POLICY_FIFO;
    logic busy, done, success, was_hit, did_evict;
    logic [3:0] slot_index;
    logic [31:0] access_total, hit_total, miss_total, evict_total;

    assoc_page_table_replacement_core #(.SLOT_COUNT(NSLOT)) u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .process_id(process_id), .page_number(page_number),
        .page_mapped(page_mapped), .policy_we(policy_we),
        .policy_wdata(policy_wdata), .done(done), .success(success),
        .was_hit(was_hit), .slot_index(slot_index), .did_evict(did_evict),
        .access_total(access_total), .hit_total(hit_total),
        .miss_total(miss_total), .evict_total(evict_total)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [1:0]  pm_policy;
    logic        pm_valid [NSLOT];
    logic [15:0] pm_owner [NSLOT];
    logic [19:0] pm_page [NSLOT];
    logic [31:0] pm_recent [NSLOT];
    logic [31:0] pm_uses [NSLOT];
    logic        pm_ref [NSLOT];
    logic [31:0] pm_insert [NSLOT];
    logic [3:0]  pm_hand;
    logic [31:0] pm_time;
    logic [15:0] pm_tracked;
    logic        pm_tracking;
    logic [31:0] pm_acc, pm_hits, pm_miss, pm_evs;

    req_t  pending_reqs[$];
    resp_t expected_resps[$];
    int    errors = 0;
    int    send_idle_pct = 6;
    int    quiet_cycles = 0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void drop_owner(input logic [15:0] pid);
        for (int s = 0; s < NSLOT; s++)
            if (pm_valid[s] && pm_owner[s] == pid)
            begin
                pm_valid[s] = 0; pm_owner[s] = '0; pm_page[s] = '0;
                pm_recent[s] = '0; pm_uses[s] = '0; pm_ref[s] = 0;
                pm_insert[s] = '0;
            end
    endfunction

    function automatic int pick_victim();
        int v;
        v = 0;
        case (pm_policy)
            aptr_pkg::POLICY_FIFO: for (int s = 1; s < NSLOT; s++)
                if (pm_insert[s] < pm_insert[v]) v = s;
            aptr_pkg::POLICY_LRU: for (int s = 1; s < NSLOT; s++)
                if (pm_recent[s] < pm_recent[v]) v = s;
            aptr_pkg::POLICY_LFU: for (int s = 1; s < NSLOT; s++)
                if (pm_uses[s] < pm_uses[v] ||
                    (pm_uses[s] == pm_uses[v] && pm_recent[s] < pm_recent[v])) v = s;
            default:
            begin
                // sweep: clear set marks until a clear one is found
                for (int n = 0; n < 2 * NSLOT; n++)
                begin
                    v = int'(pm_hand);
                    pm_hand = pm_hand + 4'd1;
                    if (!pm_ref[v]) return v;
                    pm_ref[v] = 0;
                end
                v = 0;
            end
        endcase
        return v;
    endfunction

    function automatic resp_t predict_lookup(input req_t r);
        resp_t o;
        int f;
        bit counted;
        o = '0;
        o.success = 1;
        f = -1;
        if (r.kind == aptr_pkg::KIND_ACCESS)
        begin
            if (!r.mapped) o.success = 0;
            else
            begin
                counted = pm_tracking && r.pid == pm_tracked;
                if (counted) pm_acc++;
                for (int s = 0; s < NSLOT && f < 0; s++)
                    if (pm_valid[s] && pm_owner[s] == r.pid && pm_page[s] == r.page) f = s;
                if (f >= 0)
                begin
                    if (counted) pm_hits++;
                    pm_recent[f] = pm_time++;
                    pm_uses[f]++;
                    pm_ref[f] = 1;
                    o.hit = 1;
                end
                else
                begin
                    if (counted) pm_miss++;
                    for (int s = 0; s < NSLOT && f < 0; s++)
                        if (!pm_valid[s]) f = s;
                    if (f < 0)
                    begin
                        if (counted) pm_evs++;
                        o.evict = 1;
                        f = pick_victim();
                    end
                    pm_valid[f] = 1; pm_owner[f] = r.pid; pm_page[f] = r.page;
                    pm_insert[f] = pm_time++;
                    pm_recent[f] = pm_time++;
                    pm_uses[f] = 1; pm_ref[f] = 1;
                end
                o.slot = f[3:0];
            end
        end
        else if (r.kind == aptr_pkg::KIND_INVAL) drop_owner(r.pid);
        else if (r.kind == aptr_pkg::KIND_STATS)
        begin
            drop_owner(r.pid);
            pm_hand = '0; pm_time = aptr_pkg::TIME_RESET; pm_tracked = r.pid; pm_tracking = 1;
            pm_acc = '0; pm_hits = '0; pm_miss = '0; pm_evs = '0;
        end
        o.acc = pm_acc; o.hits = pm_hits; o.miss = pm_miss; o.evs = pm_evs;
        return o;
    endfunction

    // driver: pop pending transactions, apply policy writes only when idle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                start <= 1'b0;
            end
            else if (start)
            begin
                // hold until accepted
            end
            else
            begin
                policy_we <= 1'b0;
                if (pending_reqs.size() > 0 && !policy_we)
                begin
                    if (pending_reqs[0].wr_pol)
                    begin
                        if (expected_resps.size() == 0 && !busy)
                        begin
                            policy_we <= 1'b1;
                            policy_wdata <= pending_reqs[0].pol;
                            pm_policy = pending_reqs[0].pol;
                            void'(pending_reqs.pop_front());
                        end
                    end
                    else if ($urandom_range(99) >= send_idle_pct)
                    begin
                        req_t r;
                        r = pending_reqs.pop_front();
                        kind <= r.kind;
                        process_id <= r.pid;
                        page_number <= r.page;
                        page_mapped <= r.mapped;
                        start <= 1'b1;
                        expected_resps.push_back(predict_lookup(r));
                    end
                end
            end
        end
    end

    // monitor: compare each done pulse against the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done || (start && !busy))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (done)
            begin
                if (expected_resps.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end
                else
                begin
                    resp_t e;
                    e = expected_resps.pop_front();
                    if (success !== e.success)
                        report_mismatch("success", 32'(success), 32'(e.success));
                    if (was_hit !== e.hit)
                        report_mismatch("was_hit", 32'(was_hit), 32'(e.hit));
                    if (slot_index !== e.slot)
                        report_mismatch("slot_index", 32'(slot_index), 32'(e.slot));
                    if (did_evict !== e.evict)
                        report_mismatch("did_evict", 32'(did_evict), 32'(e.evict));
                    if (access_total !== e.acc)
                        report_mismatch("access_total", access_total, e.acc);
                    if (hit_total !== e.hits)
                        report_mismatch("hit_total", hit_total, e.hits);
                    if (miss_total !== e.miss)
                        report_mismatch("miss_total", miss_total, e.miss);
                    if (evict_total !== e.evs)
                        report_mismatch("evict_total", evict_total, e.evs);
                end
            end
            if (quiet_cycles >= WATCH_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic queue_access(input logic [1:0] k, input logic [15:0] pid,
                                input logic [19:0] pg, input logic m);
        req_t r;
        r = '0;
        r.kind = k; r.pid = pid; r.page = pg; r.mapped = m;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_policy(input logic [1:0] p);
        req_t r;
        r = '0;
        r.wr_pol = 1; r.pol = p;
        pending_reqs.push_back(r);
    endtask

    task automatic queue_random(input int n);
        logic [15:0] pid;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(99);
            // small pid/page pool keeps hits and evictions frequent
            pid = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(3));
            if (sel < 85)
                queue_access(aptr_pkg::KIND_ACCESS, pid,
                             ($urandom_range(15) == 0) ? 20'($urandom) : 20'($urandom_range(23)),
                             $urandom_range(19) != 0);
            else if (sel < 92)
                queue_access(aptr_pkg::KIND_INVAL, pid, 20'($urandom), 1'($urandom));
            else if (sel < 97)
                queue_access(aptr_pkg::KIND_STATS, pid, 20'($urandom), 1'($urandom));
            else
                queue_access(aptr_pkg::KIND_NOP, pid, 20'($urandom), 1'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_resps.size() > 0 || start)
            @(posedge clk);
        repeat (2 * NSLOT + 8) @(posedge clk);
    endtask

    initial
    begin
        pm_policy = aptr_pkg::POLICY_LFU;
        for (int s = 0; s < NSLOT; s++)
        begin
            pm_valid[s] = 0; pm_owner[s] = '0; pm_page[s] = '0; pm_recent[s] = '0;
            pm_uses[s] = '0; pm_ref[s] = 0; pm_insert[s] = '0;
        end
        pm_hand = '0; pm_time = aptr_pkg::TIME_RESET; pm_tracked = '0; pm_tracking = 0;
        pm_acc = '0; pm_hits = '0; pm_miss = '0; pm_evs = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extremes, every kind, fill, hit, eviction under reset policy
        queue_access(aptr_pkg::KIND_ACCESS, 16'hFFFF, 20'hFFFFF, 1'b1);
        queue_access(aptr_pkg::KIND_ACCESS, 16'hFFFF, 20'hFFFFF, 1'b1);
        queue_access(aptr_pkg::KIND_ACCESS, 16'h0, 20'h0, 1'b0);
        queue_access(aptr_pkg::KIND_STATS, 16'h0, 20'h0, 1'b0);
        for (int i = 0; i < 17; i++) queue_access(aptr_pkg::KIND_ACCESS, 16'h0, 20'(i), 1'b1);
        queue_access(aptr_pkg::KIND_INVAL, 16'hFFFF, 20'hFFFFF, 1'b1);
        queue_access(aptr_pkg::KIND_NOP, 16'hAAAA, 20'h55555, 1'b1);
        queue_access(aptr_pkg::KIND_ACCESS, 16'h5555, 20'hAAAAA, 1'b1);
        queue_access(aptr_pkg::KIND_INVAL, 16'h0, 20'h0, 1'b0);

        // phases per policy, extremes included; idle ratio shifts by phase
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 3) send_idle_pct = 48;
            if (ph == 6) send_idle_pct = 0;
            queue_policy(2'(ph));
            queue_random(185);
            wait_drained();
        end
        if (errors == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end
endmodule
